/* hw/rtl/ets_pkg.sv */
// Shared types, constants and tables for the epoch seconds to calendar converter.
// Used by ets_ctrl, ets_dp, epoch_seconds_to_calendar and the testbench; depends on nothing.
package ets_pkg;

  // Time constants.
  localparam int unsigned SecsPerDay  = 86400;
  localparam int unsigned SecsPerHour = 3600;
  localparam int unsigned SecsPerMin  = 60;
  localparam int unsigned BaseYear    = 1970;

  // Quotient widths of the three constant divisions.
  localparam int unsigned DayQBits  = 16;
  localparam int unsigned HourQBits = 5;
  localparam int unsigned MinQBits  = 6;

  // Field widths.
  localparam int unsigned EpochW  = 32;
  localparam int unsigned YearW   = 12;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;
  localparam int unsigned DaysW   = DayQBits;
  localparam int unsigned CntW    = 4;

  // Starting divisor of each division phase, aligned to the top quotient bit.
  localparam logic [EpochW-1:0] DayDivInit  = EpochW'(SecsPerDay * (2 ** (DayQBits - 1)));
  localparam logic [EpochW-1:0] HourDivInit = EpochW'(SecsPerHour * (2 ** (HourQBits - 1)));
  localparam logic [EpochW-1:0] MinDivInit  = EpochW'(SecsPerMin * (2 ** (MinQBits - 1)));

  // Step counts of each division phase, minus one.
  localparam logic [CntW-1:0] DayLastCnt  = CntW'(DayQBits - 1);
  localparam logic [CntW-1:0] HourLastCnt = CntW'(HourQBits - 1);
  localparam logic [CntW-1:0] MinLastCnt  = CntW'(MinQBits - 1);

  // Year residues kept as running counters.
  localparam logic [6:0] Mod100Base = 7'(BaseYear % 100);
  localparam logic [8:0] Mod400Base = 9'(BaseYear % 400);
  localparam logic [6:0] Mod100Last = 7'(99);
  localparam logic [8:0] Mod400Last = 9'(399);

  localparam logic [8:0] DaysLeapYear   = 9'(366);
  localparam logic [8:0] DaysCommonYear = 9'(365);

  localparam logic [MonthW-1:0] MonthJan = MonthW'(1);
  localparam logic [MonthW-1:0] MonthFeb = MonthW'(2);
  localparam logic [MonthW-1:0] MonthDec = MonthW'(12);

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV,
    OP_DAYS,
    OP_HOURS,
    OP_MINS,
    OP_YEAR,
    OP_MONTH
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
  } status_t;

  // Days in a month, February depending on the leap flag.
  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m,
                                                 input logic leap);
    logic [DayW-1:0] len;
    begin
      case (m)
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
        4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
        4'd2:                                        len = leap ? 5'd29 : 5'd28;
        default:                                     len = 5'd31;
      endcase
      return len;
    end
  endfunction

endpackage

/* hw/rtl/ets_ctrl.sv */
// Controller of the epoch seconds to calendar converter: sequences division,
// year and month stepping. Depends on ets_pkg.
module ets_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  input  ets_pkg::status_t status,
  output ets_pkg::cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_DAY,
    S_DAYS,
    S_DIV_HOUR,
    S_HOURS,
    S_DIV_MIN,
    S_MINS,
    S_YEAR,
    S_MONTH,
    S_DONE
  } state_t;

  state_t                   state;
  logic [ets_pkg::CntW-1:0] cnt;

  // Operation for the datapath follows from the state.
  always_comb begin
    unique case (state)
      S_IDLE:     cmd.op = req_valid ? ets_pkg::OP_LOAD : ets_pkg::OP_NONE;
      S_DIV_DAY:  cmd.op = ets_pkg::OP_DIV;
      S_DAYS:     cmd.op = ets_pkg::OP_DAYS;
      S_DIV_HOUR: cmd.op = ets_pkg::OP_DIV;
      S_HOURS:    cmd.op = ets_pkg::OP_HOURS;
      S_DIV_MIN:  cmd.op = ets_pkg::OP_DIV;
      S_MINS:     cmd.op = ets_pkg::OP_MINS;
      S_YEAR:     cmd.op = ets_pkg::OP_YEAR;
      S_MONTH:    cmd.op = ets_pkg::OP_MONTH;
      S_DONE:     cmd.op = ets_pkg::OP_NONE;
      default:    cmd.op = ets_pkg::OP_NONE;
    endcase
  end

  // State, step counter and handshake outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      req_stall <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state     <= S_DIV_DAY;
            cnt       <= ets_pkg::DayLastCnt;
            req_stall <= 1'b1;
          end
        end
        S_DIV_DAY: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_DAYS;
          end
        end
        S_DAYS: begin
          state <= S_DIV_HOUR;
          cnt   <= ets_pkg::HourLastCnt;
        end
        S_DIV_HOUR: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_HOURS;
          end
        end
        S_HOURS: begin
          state <= S_DIV_MIN;
          cnt   <= ets_pkg::MinLastCnt;
        end
        S_DIV_MIN: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_MINS;
          end
        end
        S_MINS: begin
          state <= S_YEAR;
        end
        S_YEAR: begin
          if (status.year_done) begin
            state <= S_MONTH;
          end
        end
        S_MONTH: begin
          if (status.month_done) begin
            state     <= S_DONE;
            rsp_valid <= 1'b1;
          end
        end
        S_DONE: begin
          if (!rsp_stall) begin
            state     <= S_IDLE;
            rsp_valid <= 1'b0;
            req_stall <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/ets_dp.sv */
// Datapath of the epoch seconds to calendar converter: shared restoring
// divider step, year stepper and month stepper. Depends on ets_pkg.
module ets_dp (
  input  logic                          clk,
  input  ets_pkg::cmd_t                 cmd,
  output ets_pkg::status_t              status,
  input  logic [ets_pkg::EpochW-1:0]    epoch_seconds,
  output logic [ets_pkg::YearW-1:0]     year,
  output logic [ets_pkg::MonthW-1:0]    month,
  output logic [ets_pkg::DayW-1:0]      day,
  output logic [ets_pkg::HourW-1:0]     hour,
  output logic [ets_pkg::MinuteW-1:0]   minute,
  output logic [ets_pkg::SecondW-1:0]   second
);

  logic [ets_pkg::EpochW-1:0]   rem;
  logic [ets_pkg::EpochW-1:0]   dsr;
  logic [ets_pkg::DayQBits-1:0] quo;
  logic [ets_pkg::DaysW-1:0]    days;
  logic [6:0]                   mod100;
  logic [8:0]                   mod400;

  logic                         ge;
  logic                         leap;
  logic [8:0]                   ylen;
  logic [ets_pkg::DayW-1:0]     mlen;

  // One restoring step: does the shifted divisor fit into the remainder.
  assign ge = (rem >= dsr);

  // Leap rule from the year's low bits and the running residues.
  assign leap = ((year[1:0] == 2'b00) && (mod100 != 7'd0)) || (mod400 == 9'd0);
  assign ylen = leap ? ets_pkg::DaysLeapYear : ets_pkg::DaysCommonYear;
  assign mlen = ets_pkg::month_days(month, leap);

  assign status.year_done  = (days < ets_pkg::DaysW'(ylen));
  assign status.month_done = (month == ets_pkg::MonthDec) ||
                             (days < ets_pkg::DaysW'(mlen));

  assign day = ets_pkg::DayW'(days[ets_pkg::DayW-1:0] + 1'b1);

  // Datapath registers, updated per controller operation.
  always_ff @(posedge clk) begin
    case (cmd.op)
      ets_pkg::OP_LOAD: begin
        rem    <= epoch_seconds;
        dsr    <= ets_pkg::DayDivInit;
        quo    <= '0;
        year   <= ets_pkg::YearW'(ets_pkg::BaseYear);
        mod100 <= ets_pkg::Mod100Base;
        mod400 <= ets_pkg::Mod400Base;
        month  <= ets_pkg::MonthJan;
      end
      ets_pkg::OP_DIV: begin
        if (ge) begin
          rem <= rem - dsr;
        end
        quo <= {quo[ets_pkg::DayQBits-2:0], ge};
        dsr <= dsr >> 1;
      end
      ets_pkg::OP_DAYS: begin
        days <= quo;
        dsr  <= ets_pkg::HourDivInit;
        quo  <= '0;
      end
      ets_pkg::OP_HOURS: begin
        hour <= quo[ets_pkg::HourW-1:0];
        dsr  <= ets_pkg::MinDivInit;
        quo  <= '0;
      end
      ets_pkg::OP_MINS: begin
        minute <= quo[ets_pkg::MinuteW-1:0];
        second <= rem[ets_pkg::SecondW-1:0];
      end
      ets_pkg::OP_YEAR: begin
        if (!status.year_done) begin
          days   <= days - ets_pkg::DaysW'(ylen);
          year   <= year + 1'b1;
          mod100 <= (mod100 == ets_pkg::Mod100Last) ? 7'd0 : mod100 + 1'b1;
          mod400 <= (mod400 == ets_pkg::Mod400Last) ? 9'd0 : mod400 + 1'b1;
        end
      end
      ets_pkg::OP_MONTH: begin
        if (!status.month_done) begin
          days  <= days - ets_pkg::DaysW'(mlen);
          month <= month + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* hw/rtl/epoch_seconds_to_calendar.sv */
// Top level of the epoch seconds to calendar converter: controller plus datapath.
// Depends on ets_pkg, ets_ctrl and ets_dp.

// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 into
// the Gregorian year, month, day, hour, minute and second. One item is handled
// at a time: req_stall is high from the transfer of an input until its result
// has been taken. An item passes through three constant divisions (one
// quotient bit per cycle through a shared restoring divider, plus a step per
// phase that stores its quotient), then steps one year at a time past 1970
// (up to 136) and one month at a time past January (up to 11), each ending
// with a final check; the longest conversion is for a date late in 2105. The
// result is held in output registers until its transfer.
module epoch_seconds_to_calendar (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [ets_pkg::EpochW-1:0]    epoch_seconds,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [ets_pkg::YearW-1:0]     year,
  output logic [ets_pkg::MonthW-1:0]    month,
  output logic [ets_pkg::DayW-1:0]      day,
  output logic [ets_pkg::HourW-1:0]     hour,
  output logic [ets_pkg::MinuteW-1:0]   minute,
  output logic [ets_pkg::SecondW-1:0]   second
);

  ets_pkg::cmd_t    cmd;
  ets_pkg::status_t status;

  // Sequencer.
  ets_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic and result registers.
  ets_dp u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .status        (status),
    .epoch_seconds (epoch_seconds),
    .year          (year),
    .month         (month),
    .day           (day),
    .hour          (hour),
    .minute        (minute),
    .second        (second)
  );

  // A pending result keeps the input side closed.
  assert property (@(posedge clk) disable iff (rst) rsp_valid |-> req_stall)
    else $error("result pending while input open");

  // An input transfer closes the input side on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
                   (req_valid && !req_stall) |=> (req_stall && !rsp_valid))
    else $error("input side not closed after transfer");

  // A delivered result carries a legal month and time of day.
  assert property (@(posedge clk) disable iff (rst)
                   rsp_valid |-> (month >= 4'd1 && month <= 4'd12 &&
                                  hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59))
    else $error("result field out of range");

endmodule

/* test/testbench.sv */
// Self-checking testbench for the epoch seconds to calendar converter.
// Depends on ets_pkg and the epoch_seconds_to_calendar RTL; reads no files.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // One converted date and time, at the widths of the result ports.
  typedef struct packed {
    logic [ets_pkg::YearW-1:0]   year;
    logic [ets_pkg::MonthW-1:0]  month;
    logic [ets_pkg::DayW-1:0]    day;
    logic [ets_pkg::HourW-1:0]   hour;
    logic [ets_pkg::MinuteW-1:0] minute;
    logic [ets_pkg::SecondW-1:0] second;
  } date_time_t;

  // A directed probe: the timestamp, and the date when it is typed in by hand.
  typedef struct packed {
    logic [ets_pkg::EpochW-1:0] secs;
    logic                       typed;
    date_time_t                 date;
  } probe_t;

  typedef enum logic [2:0] {
    PICK_ANY,
    PICK_MIDNIGHT,
    PICK_YEAR_EDGE,
    PICK_EARLY,
    PICK_LATE
  } pick_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_COIN,
    STALL_LONG
  } stall_mode_t;

  localparam int unsigned RandomItems = 400;
  localparam int unsigned DrainCycles = 200;
  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned MaxDays     = 49710;
  localparam int unsigned CommonMonthDays [12] = '{31, 28, 31, 30, 31, 30,
                                                   31, 31, 30, 31, 30, 31};

  // Directed probes: extremes, day, month and year edges, leap and non-leap
  // centuries, the signed 32-bit rollover and alternating bit patterns.
  localparam int NumProbes = 24;
  localparam probe_t Probes [NumProbes] = '{
    '{32'd0,          1'b1, '{12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0}},
    '{32'd59,         1'b0, '0},
    '{32'd3599,       1'b0, '0},
    '{32'd86399,      1'b1, '{12'd1970, 4'd1, 5'd1, 5'd23, 6'd59, 6'd59}},
    '{32'd86400,      1'b1, '{12'd1970, 4'd1, 5'd2, 5'd0, 6'd0, 6'd0}},
    '{32'd2678400,    1'b0, '0},
    '{32'd28857600,   1'b0, '0},
    '{32'd31535999,   1'b0, '0},
    '{32'd31536000,   1'b0, '0},
    '{32'd68169600,   1'b0, '0},
    '{32'd94608000,   1'b0, '0},
    '{32'd94694400,   1'b0, '0},
    '{32'd951782400,  1'b0, '0},
    '{32'd978220800,  1'b0, '0},
    '{32'd978307200,  1'b0, '0},
    '{32'd2147483647, 1'b0, '0},
    '{32'd2147483648, 1'b0, '0},
    '{32'd4102444799, 1'b0, '0},
    '{32'd4107542399, 1'b0, '0},
    '{32'd4107542400, 1'b0, '0},
    '{32'd4294944000, 1'b0, '0},
    '{32'hFFFFFFFF,   1'b1, '{12'd2106, 4'd2, 5'd7, 5'd6, 6'd28, 6'd15}},
    '{32'hAAAAAAAA,   1'b0, '0},
    '{32'h55555555,   1'b0, '0}
  };

  logic                         clk;
  logic                         rst           = 1'b1;
  logic                         req_valid     = 1'b0;
  logic                         req_stall;
  logic [ets_pkg::EpochW-1:0]   epoch_seconds = '0;
  logic                         rsp_valid;
  logic                         rsp_stall     = 1'b0;
  logic [ets_pkg::YearW-1:0]    year;
  logic [ets_pkg::MonthW-1:0]   month;
  logic [ets_pkg::DayW-1:0]     day;
  logic [ets_pkg::HourW-1:0]    hour;
  logic [ets_pkg::MinuteW-1:0]  minute;
  logic [ets_pkg::SecondW-1:0]  second;

  date_time_t  pending_dates [$];
  int unsigned sent_count     = 0;
  int unsigned checked_count  = 0;
  int unsigned mismatch_count = 0;
  int unsigned leap_day_count = 0;
  int unsigned first_year     = 4095;
  int unsigned last_year      = 0;
  int unsigned burst_left     = 0;
  int unsigned cycle_count    = 0;

  epoch_seconds_to_calendar u_top (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .epoch_seconds (epoch_seconds),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .year          (year),
    .month         (month),
    .day           (day),
    .hour          (hour),
    .minute        (minute),
    .second        (second)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gregorian leap rule.
  function automatic bit is_leap_year(input int unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  // Expected calendar date and time of day for a timestamp.
  function automatic date_time_t to_calendar(input logic [ets_pkg::EpochW-1:0] secs);
    date_time_t  d;
    int unsigned days, rem, yr, mon, ylen, mlen;
    days     = secs / ets_pkg::SecsPerDay;
    rem      = secs % ets_pkg::SecsPerDay;
    d.hour   = ets_pkg::HourW'(rem / ets_pkg::SecsPerHour);
    rem      = rem % ets_pkg::SecsPerHour;
    d.minute = ets_pkg::MinuteW'(rem / ets_pkg::SecsPerMin);
    d.second = ets_pkg::SecondW'(rem % ets_pkg::SecsPerMin);
    // Walk whole years from the epoch year.
    yr   = ets_pkg::BaseYear;
    ylen = is_leap_year(yr) ? 366 : 365;
    while (days >= ylen) begin
      days -= ylen;
      yr++;
      ylen = is_leap_year(yr) ? 366 : 365;
    end
    // Walk whole months; December takes whatever is left.
    mon = 1;
    while (mon < 12) begin
      mlen = (mon == 2 && is_leap_year(yr)) ? 29 : CommonMonthDays[mon-1];
      if (days < mlen) break;
      days -= mlen;
      mon++;
    end
    d.year  = ets_pkg::YearW'(yr);
    d.month = ets_pkg::MonthW'(mon);
    d.day   = ets_pkg::DayW'(days + 1);
    return d;
  endfunction

  // Offer one timestamp and hold it until the transfer.
  task automatic send_date(input logic [ets_pkg::EpochW-1:0] secs, input logic typed,
                           input date_time_t typed_date);
    req_valid     <= 1'b1;
    epoch_seconds <= secs;
    do @(posedge clk); while (req_stall);
    pending_dates.push_back(typed ? typed_date : to_calendar(secs));
    sent_count++;
  endtask

  // Burst pacing: after a burst, drop valid for a random gap or go straight on.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold off the sender until every outstanding date has come back.
  task automatic wait_for_drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_dates.size() != 0);
  endtask

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // Stimulus: reset, directed probes, then random timestamps.
  initial begin : stimulus
    date_time_t                 none;
    logic [ets_pkg::EpochW-1:0] secs;
    longint unsigned            wide;
    pick_t                      pick;
    int unsigned                yr, days;
    none = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NumProbes; i++) begin
      send_date(Probes[i].secs, Probes[i].typed, Probes[i].date);
      pace_sender();
    end
    wait_for_drain();

    for (int n = 0; n < RandomItems; n++) begin
      pick = pick_t'($urandom_range(0, 4));
      case (pick)
        PICK_MIDNIGHT: begin
          // Around a day boundary, at either end of the day or inside it.
          wide = longint'($urandom_range(0, MaxDays)) * ets_pkg::SecsPerDay;
          case ($urandom_range(0, 2))
            0:       wide += ets_pkg::SecsPerDay - 1;
            1:       wide += $urandom_range(0, ets_pkg::SecsPerDay - 1);
            default: wide += 0;
          endcase
          secs = (wide > 64'hFFFFFFFF) ? 32'hFFFFFFFF : ets_pkg::EpochW'(wide);
        end
        PICK_YEAR_EDGE: begin
          // First second of a year or last second of the one before.
          yr   = $urandom_range(1971, 2106);
          days = 0;
          for (int unsigned y = ets_pkg::BaseYear; y < yr; y++)
            days += is_leap_year(y) ? 366 : 365;
          wide = longint'(days) * ets_pkg::SecsPerDay;
          secs = ets_pkg::EpochW'(wide) - ets_pkg::EpochW'($urandom_range(0, 1));
        end
        PICK_EARLY: secs = ets_pkg::EpochW'($urandom_range(0, 100000000));
        PICK_LATE:  secs = 32'hFFFFFFFF - ets_pkg::EpochW'($urandom_range(0, 100000000));
        default:    secs = ets_pkg::EpochW'($urandom());
      endcase
      send_date(secs, 1'b0, none);
      pace_sender();
      if ($urandom_range(0, 40) == 0) wait_for_drain();
    end
    req_valid <= 1'b0;

    // Let every outstanding date arrive, then watch for strays.
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("summary: %0d timestamps sent, %0d dates checked, years %0d to %0d, %0d leap days",
             sent_count, checked_count, first_year, last_year, leap_day_count);
    $display("summary: %0d field mismatches", mismatch_count);
    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Result side: check each transfer and drive stall in stretches of
  // no stalls, coin-flip stalls and long holds.
  initial begin : receiver
    date_time_t  want;
    stall_mode_t mode;
    int unsigned stretch_left, hold_left;
    bit          hold_on, stall_next;
    mode         = STALL_NONE;
    stretch_left = 0;
    hold_left    = 0;
    hold_on      = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        if (pending_dates.size() == 0) begin
          mismatch_count++;
          $display("%0t: result transfer with no date expected, actual %0d-%0d-%0d",
                   $time, year, month, day);
        end else begin
          want = pending_dates.pop_front();
          check_field("year", want.year, year);
          check_field("month", want.month, month);
          check_field("day", want.day, day);
          check_field("hour", want.hour, hour);
          check_field("minute", want.minute, minute);
          check_field("second", want.second, second);
          checked_count++;
          if (want.month == 2 && want.day == 29) leap_day_count++;
          if (want.year < first_year) first_year = want.year;
          if (want.year > last_year) last_year = want.year;
        end
      end

      // Pick the next stall pattern once the current stretch runs out.
      if (stretch_left == 0) begin
        mode         = stall_mode_t'($urandom_range(0, 2));
        stretch_left = $urandom_range(50, 600);
      end
      stretch_left--;
      case (mode)
        STALL_NONE: stall_next = 1'b0;
        STALL_COIN: stall_next = ($urandom_range(0, 1) == 1);
        default: begin
          if (hold_left == 0) begin
            hold_on   = !hold_on;
            hold_left = $urandom_range(1, 40);
          end
          hold_left--;
          stall_next = hold_on;
        end
      endcase
      rsp_stall <= stall_next;
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

endmodule

/* sim.f */
hw/rtl/ets_pkg.sv
hw/rtl/ets_ctrl.sv
hw/rtl/ets_dp.sv
hw/rtl/epoch_seconds_to_calendar.sv
test/testbench.sv
